>>> hw/rtl/ebma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the endian byte memory access core.
// Holds operation and size codes, lane and queue constants and the command type.
// No dependencies.
package ebma_pkg;

    // Operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Access size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Byte lanes in one memory word
    localparam int NUM_LANES = 4;

    // Command queue between front and back, depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // Classified request, placed in memory lane order
    typedef struct packed {
        logic        op;
        logic [1:0]  size;
        logic [1:0]  offset;
        logic        err;
        logic        big_endian;
        logic [29:0] word_addr;
        logic [31:0] wdata_lanes;
        logic [3:0]  byte_en;
    } ebma_cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/ebma_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Request and response channel interfaces of the endian byte memory access core.
// Valid/ready handshake; no package dependency.
interface ebma_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [1:0]  access_size;
    logic [31:0] byte_address;
    logic [31:0] write_data;

    modport source (output valid, output operation, output access_size,
                    output byte_address, output write_data, input ready);
    modport sink   (input valid, input operation, input access_size,
                    input byte_address, input write_data, output ready);
endinterface

interface ebma_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        access_error;

    modport source (output valid, output read_data, output access_error, input ready);
    modport sink   (input valid, input read_data, input access_error, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/endian_byte_memory_access_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the endian byte memory access core.
// Depends on ebma_pkg, ebma_if, ebma_front, ebma_queue and ebma_back.
//
//  Channel  Role    Handshake     Carries
//  req      sink    valid/ready   operation, access_size, byte_address, write_data
//  rsp      source  valid/ready   read_data, access_error
//  cfg      input   write enable  big_endian (cfg_write_data)
//
// Sustained rate is one transaction per cycle while rsp.ready stays high, set by
// the single memory port. A response passes through the queue, the memory read
// stage and the response register after its request is accepted. Reset clears
// control only; memory contents are undefined until written. The two-entry queue
// lets the request side keep going while a response waits on rsp.ready.
module endian_byte_memory_access_core #(
    parameter int MEM_WORDS = 1024
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_write_en,
    input  wire logic cfg_write_data,
    ebma_req_if.sink  req,
    ebma_rsp_if.source rsp
);
    import ebma_pkg::*;

    ebma_cmd_t front_cmd;
    ebma_cmd_t back_cmd;
    logic      push_valid;
    logic      push_ready;
    logic      pop_valid;
    logic      pop_ready;

    ebma_front #(
        .MEM_WORDS(MEM_WORDS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .req           (req),
        .cmd           (front_cmd),
        .push_valid    (push_valid),
        .push_ready    (push_ready)
    );

    ebma_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cmd  (front_cmd),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .pop_cmd   (back_cmd),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready)
    );

    ebma_back #(
        .MEM_WORDS(MEM_WORDS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (back_cmd),
        .cmd_valid(pop_valid),
        .cmd_ready(pop_ready),
        .rsp      (rsp)
    );

endmodule
`default_nettype wire

>>> hw/rtl/ebma_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: holds the byte order register, accepts requests and classifies them
// (alignment, bounds, lane placement). Depends on ebma_pkg and ebma_if.
module ebma_front #(
    parameter int MEM_WORDS = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_en,
    input  wire logic               cfg_write_data,
    ebma_req_if.sink                req,
    output ebma_pkg::ebma_cmd_t     cmd,
    output logic                    push_valid,
    input  wire logic               push_ready
);
    import ebma_pkg::*;

    logic        big_endian_reg;
    logic [1:0]  offset;
    logic [29:0] word_addr;
    logic        err;
    logic [31:0] ordered;
    logic [3:0]  mask;

    // Byte order register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            big_endian_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            big_endian_reg <= cfg_write_data;
        end
    end

    assign offset    = req.byte_address[1:0];
    assign word_addr = req.byte_address[31:2];

    // Alignment and bounds; every legal access stays inside one word
    always_comb
    begin
        case (req.access_size)
            SIZE_BYTE: err = 1'b0;
            SIZE_HALF: err = (offset == 2'd3);
            SIZE_WORD: err = (offset != 2'd0);
            default:   err = 1'b1;
        endcase
        if (word_addr >= 30'(MEM_WORDS))
        begin
            err = 1'b1;
        end
    end

    // Value bytes in memory order, lowest address in the low byte
    always_comb
    begin
        case (req.access_size)
            SIZE_BYTE:
            begin
                ordered = {24'd0, req.write_data[7:0]};
                mask    = 4'b0001;
            end
            SIZE_HALF:
            begin
                ordered = big_endian_reg ?
                          {16'd0, req.write_data[7:0], req.write_data[15:8]} :
                          {16'd0, req.write_data[15:0]};
                mask    = 4'b0011;
            end
            SIZE_WORD:
            begin
                ordered = big_endian_reg ?
                          {req.write_data[7:0], req.write_data[15:8],
                           req.write_data[23:16], req.write_data[31:24]} :
                          req.write_data;
                mask    = 4'b1111;
            end
            default:
            begin
                ordered = 32'd0;
                mask    = 4'b0000;
            end
        endcase
    end

    // Command to the queue
    always_comb
    begin
        cmd.op          = req.operation;
        cmd.size        = req.access_size;
        cmd.offset      = offset;
        cmd.err         = err;
        cmd.big_endian  = big_endian_reg;
        cmd.word_addr   = word_addr;
        cmd.wdata_lanes = ordered << {offset, 3'b000};
        cmd.byte_en     = (err || (req.operation != OP_WRITE)) ? 4'b0000 : (mask << offset);
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

endmodule
`default_nettype wire

>>> hw/rtl/ebma_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Short command queue between front and back ends.
// Depends on ebma_pkg.
module ebma_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ebma_pkg::ebma_cmd_t push_cmd,
    input  wire logic                push_valid,
    output logic                     push_ready,
    output ebma_pkg::ebma_cmd_t      pop_cmd,
    output logic                     pop_valid,
    input  wire logic                pop_ready
);
    import ebma_pkg::*;

    ebma_cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/ebma_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: byte-lane data memory, read stage and response register.
// Depends on ebma_pkg and ebma_if.
module ebma_back #(
    parameter int MEM_WORDS = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ebma_pkg::ebma_cmd_t cmd,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    ebma_rsp_if.source               rsp
);
    import ebma_pkg::*;

    localparam int IDX_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    logic [IDX_W-1:0] idx;
    logic             pop;
    logic             s1_adv;
    logic             s1_valid_reg;
    ebma_cmd_t        s1_cmd_reg;
    logic [31:0]      rd_word;
    logic [31:0]      shifted;
    logic [31:0]      fmt_data;
    logic             out_valid_reg;
    logic [31:0]      read_data_reg;
    logic             access_error_reg;

    assign idx       = cmd.word_addr[IDX_W-1:0];
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign pop       = cmd_valid && (!s1_valid_reg || s1_adv);
    assign cmd_ready = !s1_valid_reg || s1_adv;

    // One memory per byte lane, written with byte enables, read registered
    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        logic [7:0] mem [MEM_WORDS];
        logic [7:0] rd_byte_reg;

        always_ff @(posedge clk)
        begin
            if (pop)
            begin
                if (cmd.byte_en[l])
                begin
                    mem[idx] <= cmd.wdata_lanes[8*l +: 8];
                end
                rd_byte_reg <= mem[idx];
            end
        end

        assign rd_word[8*l +: 8] = rd_byte_reg;
    end

    // Read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_cmd_reg <= cmd;
        end
    end

    // Bring the addressed bytes down and put them in value order
    assign shifted = rd_word >> {s1_cmd_reg.offset, 3'b000};

    always_comb
    begin
        case (s1_cmd_reg.size)
            SIZE_BYTE: fmt_data = {24'd0, shifted[7:0]};
            SIZE_HALF: fmt_data = s1_cmd_reg.big_endian ?
                                  {16'd0, shifted[7:0], shifted[15:8]} :
                                  {16'd0, shifted[15:0]};
            SIZE_WORD: fmt_data = s1_cmd_reg.big_endian ?
                                  {shifted[7:0], shifted[15:8],
                                   shifted[23:16], shifted[31:24]} :
                                  shifted;
            default:   fmt_data = 32'd0;
        endcase
        if (s1_cmd_reg.err || (s1_cmd_reg.op == OP_WRITE))
        begin
            fmt_data = 32'd0;
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            read_data_reg    <= fmt_data;
            access_error_reg <= s1_cmd_reg.err;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = read_data_reg;
    assign rsp.access_error = access_error_reg;

endmodule
`default_nettype wire

>>> hw/rtl/ebma_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the endian byte memory access core, and its bind.
// Depends only on the top level's ports.
module ebma_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [31:0] rsp_read_data,
    input wire logic        rsp_access_error
);
    logic       req_fire;
    logic       rsp_fire;
    logic [2:0] pending_reg;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // Transactions accepted but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(req_fire) - 3'(rsp_fire);
        end
    end

    // No response while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

    // A response always answers an accepted request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 3'd0)
        else $error("response without outstanding request");

    // Queue, read stage and response register bound what can be in flight
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("too many outstanding transactions");

    // Rejected transactions return zero data
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_access_error |-> rsp_read_data == 32'd0)
        else $error("error response with nonzero data");

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
                                    && $stable(rsp_access_error))
        else $error("stalled response changed");

endmodule

bind endian_byte_memory_access_core ebma_checker u_ebma_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_read_data   (rsp.read_data),
    .rsp_access_error(rsp.access_error)
);
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench for endian_byte_memory_access_core: byte, halfword and word accesses
// in both byte orders, checked against a byte-level memory model.
// Depends on ebma_pkg, ebma_if and the core RTL.
module tb;
    import ebma_pkg::*;

    localparam int          MEM_WORDS    = 1024;
    localparam int          STORE_BYTES  = 4 * MEM_WORDS;
    localparam logic [1:0]  SIZE_NONE    = 2'd3;   // unused size code
    localparam int          PHASE_ITEMS  = 100;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          CYCLE_LIMIT  = 200000;

    // Expected response of one transaction
    typedef struct packed {
        logic [31:0] read_data;
        logic        access_error;
    } mem_rsp_t;

    // Byte store with written marks, byte order setting and pending responses
    class endian_mem_model;
        logic [7:0] store_bytes [STORE_BYTES];
        bit         filled [STORE_BYTES];
        bit         big_endian;
        mem_rsp_t   due_responses [$];
        int         mismatches;

        // Alignment and bounds check; n returns the access width in bytes
        function bit legal_access(logic [1:0] size, logic [31:0] addr,
                                  output int unsigned n);
            bit ok;
            ok = 1'b1;
            case (size)
                SIZE_BYTE: n = 1;
                SIZE_HALF:
                begin
                    n = 2;
                    if (addr[1:0] == 2'd3)
                        ok = 1'b0;
                end
                SIZE_WORD:
                begin
                    n = 4;
                    if (addr[1:0] != 2'd0)
                        ok = 1'b0;
                end
                default:
                begin
                    n = 1;
                    ok = 1'b0;
                end
            endcase
            // no wrap-around: compare in 64 bits
            if ({32'd0, addr} + 64'(n) > 64'(STORE_BYTES))
                ok = 1'b0;
            return ok;
        endfunction

        // A read is allowed when rejected anyway, or when every byte was written
        function bit read_allowed(logic [1:0] size, logic [31:0] addr);
            int unsigned n;
            int unsigned i;
            if (!legal_access(size, addr, n))
                return 1'b1;
            for (i = 0; i < n; i++)
                if (!filled[addr + i])
                    return 1'b0;
            return 1'b1;
        endfunction

        function int unsigned lane_shift(int unsigned n, int unsigned i);
            return big_endian ? 8 * (n - 1 - i) : 8 * i;
        endfunction

        // Apply an accepted request and queue the response it must produce
        function void note_access(logic op, logic [1:0] size, logic [31:0] addr,
                                  logic [31:0] data);
            mem_rsp_t    rsp;
            int unsigned n;
            int unsigned i;
            logic [31:0] value;
            rsp = '0;
            value = '0;
            if (!legal_access(size, addr, n)) begin
                rsp.access_error = 1'b1;
            end
            else if (op == OP_WRITE) begin
                for (i = 0; i < n; i++) begin
                    store_bytes[addr + i] = 8'(data >> lane_shift(n, i));
                    filled[addr + i] = 1'b1;
                end
            end
            else begin
                for (i = 0; i < n; i++)
                    value |= 32'(store_bytes[addr + i]) << lane_shift(n, i);
                rsp.read_data = value;
            end
            due_responses.push_back(rsp);
        endfunction

        // Compare a delivered response with the oldest pending one
        function void check_response(logic [31:0] rdata, logic err);
            mem_rsp_t want;
            if (due_responses.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected response read_data=%h access_error=%b",
                         $time, rdata, err);
                return;
            end
            want = due_responses.pop_front();
            if (rdata !== want.read_data) begin
                mismatches++;
                $display("%0t: read_data expected %h actual %h",
                         $time, want.read_data, rdata);
            end
            if (err !== want.access_error) begin
                mismatches++;
                $display("%0t: access_error expected %b actual %b",
                         $time, want.access_error, err);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_write_data;
    bit   steady;          // no idling on either side when set
    int   cycle_count;

    endian_mem_model mem_model = new();

    ebma_req_if req_ch ();
    ebma_rsp_if rsp_ch ();

    endian_byte_memory_access_core #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req            (req_ch),
        .rsp            (rsp_ch)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Monitor: note accepted requests, check accepted responses
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready)
                mem_model.note_access(req_ch.operation, req_ch.access_size,
                                      req_ch.byte_address, req_ch.write_data);
            if (rsp_ch.valid && rsp_ch.ready)
                mem_model.check_response(rsp_ch.read_data, rsp_ch.access_error);
        end
    end

    // Response side: random stalls on ready
    initial
    begin
        rsp_ch.ready = 1'b1;
        forever begin
            @(posedge clk);
            if (!steady && $urandom_range(0, 7) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Present one transaction and hold it until accepted
    task automatic send_access(logic op, logic [1:0] size, logic [31:0] addr,
                               logic [31:0] data);
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.access_size  <= size;
        req_ch.byte_address <= addr;
        req_ch.write_data   <= data;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic sender_pause(int unsigned cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop sending and wait until every pending response has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (mem_model.due_responses.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Byte order register write, only while the core is idle
    task automatic set_byte_order(bit big);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= big;
        mem_model.big_endian = big;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // One random transaction: mostly legal accesses in a small window,
    // plus misaligned, boundary and wild-address requests
    task automatic random_access();
        int unsigned pick;
        logic        op;
        logic [1:0]  size;
        logic [31:0] addr;
        logic [31:0] data;
        pick = $urandom_range(0, 99);
        data = $urandom();
        op   = 1'($urandom_range(0, 1));
        size = 2'($urandom_range(0, 3));
        addr = 32'($urandom_range(0, STORE_BYTES - 1));
        if (pick < 8) begin
            addr = $urandom();
        end
        else if (pick < 14) begin
            case ($urandom_range(0, 2))
                0:
                begin
                    size = SIZE_WORD;
                    addr[1:0] = 2'($urandom_range(1, 3));
                end
                1:
                begin
                    size = SIZE_HALF;
                    addr[1:0] = 2'd3;
                end
                default: size = SIZE_NONE;
            endcase
        end
        else if (pick < 20) begin
            // around the top of the store
            size = 2'($urandom_range(0, 2));
            addr = 32'(STORE_BYTES - 8 + $urandom_range(0, 11));
        end
        else begin
            size = 2'($urandom_range(0, 2));
            if (pick < 85)
                addr = 32'($urandom_range(0, 127));
            if (size == SIZE_WORD)
                addr[1:0] = 2'd0;
            else if (size == SIZE_HALF && addr[1:0] == 2'd3)
                addr[1:0] = 2'd2;
            op = ($urandom_range(0, 9) < 6) ? OP_READ : OP_WRITE;
        end
        // never read bytes that were not written yet
        if (op == OP_READ && !mem_model.read_allowed(size, addr))
            op = OP_WRITE;
        send_access(op, size, addr, data);
    endtask

    // Stimulus
    initial
    begin
        int phase;
        int k;
        rst_n               = 1'b0;
        cfg_write_en        = 1'b0;
        cfg_write_data      = 1'b0;
        steady              = 1'b0;
        cycle_count         = 0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_READ;
        req_ch.access_size  = SIZE_BYTE;
        req_ch.byte_address = '0;
        req_ch.write_data   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, little endian: all sizes, store edges, every reject reason
        set_byte_order(1'b0);
        send_access(OP_WRITE, SIZE_WORD, 32'd0, 32'h1122_3344);
        send_access(OP_READ,  SIZE_WORD, 32'd0, 32'h0);
        send_access(OP_READ,  SIZE_BYTE, 32'd1, 32'h0);
        send_access(OP_READ,  SIZE_HALF, 32'd2, 32'h0);
        send_access(OP_WRITE, SIZE_HALF, 32'd5, 32'hFFFF_ABCD);
        send_access(OP_READ,  SIZE_HALF, 32'd5, 32'h0);
        send_access(OP_WRITE, SIZE_WORD, 32'd4092, 32'hFFFF_FFFF);
        send_access(OP_WRITE, SIZE_HALF, 32'd4094, 32'h0000_0000);
        send_access(OP_WRITE, SIZE_BYTE, 32'd4095, 32'hFFFF_FF5A);
        send_access(OP_READ,  SIZE_WORD, 32'd4092, 32'h0);
        send_access(OP_READ,  SIZE_BYTE, 32'd4095, 32'h0);
        send_access(OP_WRITE, SIZE_WORD, 32'd2, 32'hDEAD_BEEF);
        send_access(OP_READ,  SIZE_HALF, 32'd3, 32'h0);
        send_access(OP_WRITE, SIZE_HALF, 32'd4095, 32'hFFFF_FFFF);
        send_access(OP_READ,  SIZE_WORD, 32'd4096, 32'h0);
        send_access(OP_WRITE, SIZE_BYTE, 32'd4096, 32'h0000_00FF);
        send_access(OP_WRITE, SIZE_WORD, 32'hFFFF_FFFC, 32'h0);
        send_access(OP_WRITE, SIZE_NONE, 32'd0, 32'h0);
        send_access(OP_READ,  SIZE_WORD, 32'd0, 32'h0);   // unchanged by rejects
        drain();

        // Directed, big endian: reread earlier data, new mixed-size writes
        set_byte_order(1'b1);
        send_access(OP_READ,  SIZE_WORD, 32'd0, 32'h0);
        send_access(OP_WRITE, SIZE_WORD, 32'd8, 32'hA1B2_C3D4);
        send_access(OP_READ,  SIZE_BYTE, 32'd8, 32'h0);
        send_access(OP_READ,  SIZE_HALF, 32'd9, 32'h0);
        send_access(OP_WRITE, SIZE_HALF, 32'd10, 32'h0000_1234);
        send_access(OP_READ,  SIZE_WORD, 32'd8, 32'h0);
        send_access(OP_READ,  SIZE_NONE, 32'd8, 32'h0);

        // Random phases, byte order alternating; the last one without idling
        for (phase = 0; phase < 4; phase++) begin
            drain();
            set_byte_order(1'(phase % 2));
            steady = (phase == 3);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == 1 && k == PHASE_ITEMS / 2)
                    drain();
                else if (!steady && $urandom_range(0, 6) == 0)
                    sender_pause($urandom_range(1, 8));
                random_access();
            end
        end
        drain();

        if (mem_model.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> endian_byte_memory_access_core.f
hw/rtl/ebma_pkg.sv
hw/rtl/ebma_if.sv
hw/rtl/ebma_front.sv
hw/rtl/ebma_queue.sv
hw/rtl/ebma_back.sv
hw/rtl/endian_byte_memory_access_core.sv
hw/rtl/ebma_checker.sv
sim/tb.sv
